>>> design/urm_pkg.sv
`default_nettype none
package urm_pkg;

  localparam int TICK_BITS = 16;
  localparam int CMP_BITS  = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  localparam int DIST_BITS = 13;
  localparam logic [DIST_BITS-1:0] DIST_SAT = {DIST_BITS{1'b1}};

  localparam int unsigned SOUND_NUM = 343;
  localparam int unsigned SOUND_DEN = 2000;

  // Pulses at or above this width saturate the distance.
  localparam int unsigned SAT_PULSE =
      ((32'(DIST_SAT) + 32'd1) * SOUND_DEN + SOUND_NUM - 32'd1) / SOUND_NUM;

  // Below SAT_PULSE the pulse fits in 16 bits and the scaled product is exact.
  localparam int MUL_IN_BITS = 16;
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_BITS  = 25;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT =
      RECIP_BITS'(((64'(SOUND_NUM) << RECIP_SHIFT) + 64'(SOUND_DEN) - 64'd1) / 64'(SOUND_DEN));
  localparam int PROD_BITS = MUL_IN_BITS + RECIP_BITS;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_IDLE_WAIT,
    PH_SETTLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  typedef enum logic [2:0] {
    R_OK,
    R_NOT_READY,
    R_IDLE_HIGH,
    R_NO_RISE,
    R_NO_FALL
  } reason_t;

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_THRESHOLD,
    REG_ECHO_TIMEOUT,
    REG_IDLE_TIMEOUT,
    REG_TRIGGER,
    REG_SETTLE,
    REG_MIN_DIST,
    REG_MAX_DIST
  } reg_idx_t;

  typedef struct packed {
    logic                 sensor_enabled;
    logic [DIST_BITS-1:0] block_limit;
    logic [15:0]          echo_timeout_us;
    logic [15:0]          idle_timeout_us;
    logic [7:0]           trigger_us;
    logic [7:0]           settle_us;
    logic [DIST_BITS-1:0] min_distance_mm;
    logic [DIST_BITS-1:0] max_distance_mm;
  } cfg_t;

  typedef struct packed {
    logic                 trig;
    logic                 busy;
    logic                 done;
    logic                 finish;
    logic                 fail;
    reason_t              code;
    logic [TICK_BITS-1:0] pulse;
  } step_t;

endpackage
`default_nettype wire

>>> design/urm_regs.sv
`default_nettype none
module urm_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [urm_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [urm_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [urm_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output urm_pkg::cfg_t                       cfg
);
  import urm_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_enabled  <= 1'b0;
      cfg.block_limit     <= 13'd250;
      cfg.echo_timeout_us <= 16'd30000;
      cfg.idle_timeout_us <= 16'd1000;
      cfg.trigger_us      <= 8'd10;
      cfg.settle_us       <= 8'd2;
      cfg.min_distance_mm <= 13'd20;
      cfg.max_distance_mm <= 13'd4000;
    end else if (wr_en) begin
      case (idx)
        REG_ENABLE:       cfg.sensor_enabled  <= pwdata[0];
        REG_THRESHOLD:    cfg.block_limit     <= pwdata[DIST_BITS-1:0];
        REG_ECHO_TIMEOUT: cfg.echo_timeout_us <= pwdata[15:0];
        REG_IDLE_TIMEOUT: cfg.idle_timeout_us <= pwdata[15:0];
        REG_TRIGGER:      cfg.trigger_us      <= pwdata[7:0];
        REG_SETTLE:       cfg.settle_us       <= pwdata[7:0];
        REG_MIN_DIST:     cfg.min_distance_mm <= pwdata[DIST_BITS-1:0];
        REG_MAX_DIST:     cfg.max_distance_mm <= pwdata[DIST_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:       prdata = DATA_BITS'(cfg.sensor_enabled);
      REG_THRESHOLD:    prdata = DATA_BITS'(cfg.block_limit);
      REG_ECHO_TIMEOUT: prdata = DATA_BITS'(cfg.echo_timeout_us);
      REG_IDLE_TIMEOUT: prdata = DATA_BITS'(cfg.idle_timeout_us);
      REG_TRIGGER:      prdata = DATA_BITS'(cfg.trigger_us);
      REG_SETTLE:       prdata = DATA_BITS'(cfg.settle_us);
      REG_MIN_DIST:     prdata = DATA_BITS'(cfg.min_distance_mm);
      REG_MAX_DIST:     prdata = DATA_BITS'(cfg.max_distance_mm);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/urm_ctrl.sv
`default_nettype none
module urm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire urm_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          start_request,
  input  wire logic          echo_level,
  output logic               step_valid,
  input  wire logic          step_ready,
  output urm_pkg::step_t     step
);
  import urm_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic [TICK_BITS-1:0] phase_ticks;
  logic [TICK_BITS-1:0] phase_ticks_next;
  logic [TICK_BITS-1:0] ticks_inc;
  logic [CMP_BITS-1:0]  ticks_cmp;
  logic                 at_max;
  logic                 exp_idle;
  logic                 exp_echo;
  logic                 exp_settle;
  logic                 exp_trig;
  logic                 accept;
  step_t                res;

  assign in_ready = !step_valid || step_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ticks_inc  = (phase_ticks != TICK_MAX) ? phase_ticks + 1'b1 : phase_ticks;
    ticks_cmp  = CMP_BITS'(ticks_inc);
    at_max     = (ticks_inc == TICK_MAX);
    exp_idle   = at_max || (ticks_cmp >= CMP_BITS'(cfg.idle_timeout_us));
    exp_echo   = at_max || (ticks_cmp >= CMP_BITS'(cfg.echo_timeout_us));
    exp_settle = at_max || (ticks_cmp >= CMP_BITS'(cfg.settle_us));
    exp_trig   = at_max || (ticks_cmp >= CMP_BITS'(cfg.trigger_us));

    phase_next       = phase;
    phase_ticks_next = phase_ticks;
    res              = '0;
    res.code         = R_OK;
    res.pulse        = ticks_inc;

    case (phase)
      PH_IDLE: begin
        if (start_request) begin
          phase_ticks_next = '0;
          if (!cfg.sensor_enabled) begin
            res.fail = 1'b1;
            res.done = 1'b1;
            res.code = R_NOT_READY;
          end else if (echo_level) begin
            phase_next = PH_IDLE_WAIT;
          end else begin
            phase_next = (cfg.settle_us != 8'd0) ? PH_SETTLE : PH_TRIG;
          end
        end
      end
      PH_IDLE_WAIT: begin
        if (!echo_level) begin
          phase_ticks_next = '0;
          phase_next       = (cfg.settle_us != 8'd0) ? PH_SETTLE : PH_TRIG;
        end else if (exp_idle) begin
          phase_ticks_next = '0;
          phase_next       = PH_IDLE;
          res.fail         = 1'b1;
          res.done         = 1'b1;
          res.code         = R_IDLE_HIGH;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      PH_SETTLE: begin
        if (exp_settle) begin
          phase_ticks_next = '0;
          phase_next       = PH_TRIG;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      PH_TRIG: begin
        res.trig = 1'b1;
        if (exp_trig) begin
          phase_ticks_next = '0;
          phase_next       = PH_RISE;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      PH_RISE: begin
        if (echo_level) begin
          phase_ticks_next = '0;
          phase_next       = PH_FALL;
        end else if (exp_echo) begin
          phase_ticks_next = '0;
          phase_next       = PH_IDLE;
          res.fail         = 1'b1;
          res.done         = 1'b1;
          res.code         = R_NO_RISE;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      PH_FALL: begin
        if (!echo_level) begin
          phase_ticks_next = '0;
          phase_next       = PH_IDLE;
          res.finish       = 1'b1;
          res.done         = 1'b1;
        end else if (exp_echo) begin
          phase_ticks_next = '0;
          phase_next       = PH_IDLE;
          res.fail         = 1'b1;
          res.done         = 1'b1;
          res.code         = R_NO_FALL;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
      end
    endcase

    res.busy = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_ticks <= '0;
      step_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        phase_ticks <= phase_ticks_next;
        step_valid  <= 1'b1;
      end else if (step_ready) begin
        step_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step <= res;
    end
  end

endmodule
`default_nettype wire

>>> design/urm_dist.sv
`default_nettype none
module urm_dist (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire urm_pkg::cfg_t                  cfg,
  input  wire logic                           step_valid,
  output logic                                step_ready,
  input  wire urm_pkg::step_t                 step,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                trigger_level,
  output logic                                busy_res,
  output logic                                done_res,
  output logic                                valid_res,
  output logic                                blocked,
  output logic      [urm_pkg::DIST_BITS-1:0]  distance,
  output logic      [2:0]                     reason
);
  import urm_pkg::*;

  logic [31:0]          pulse_w;
  logic                 sat;
  logic [PROD_BITS-1:0] prod;
  logic [DIST_BITS-1:0] raw;
  logic [DIST_BITS-1:0] clamped;
  logic                 is_blocked;
  logic                 load;

  assign step_ready = !out_valid || out_ready;
  assign load       = step_valid && step_ready;

  always_comb begin
    pulse_w = 32'(step.pulse);
    sat     = (pulse_w >= SAT_PULSE);
    prod    = PROD_BITS'(pulse_w[MUL_IN_BITS-1:0]) * PROD_BITS'(RECIP_MULT);
    raw     = sat ? DIST_SAT : prod[RECIP_SHIFT +: DIST_BITS];
    if (raw < cfg.min_distance_mm) begin
      clamped = cfg.min_distance_mm;
    end else if (raw > cfg.max_distance_mm) begin
      clamped = cfg.max_distance_mm;
    end else begin
      clamped = raw;
    end
    is_blocked = (clamped < cfg.block_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      valid_res <= 1'b0;
      blocked   <= 1'b0;
      distance  <= '0;
      reason    <= R_NOT_READY;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (step.finish) begin
          valid_res <= 1'b1;
          blocked   <= is_blocked;
          distance  <= clamped;
          reason    <= R_OK;
        end else if (step.fail) begin
          valid_res <= 1'b0;
          blocked   <= 1'b0;
          distance  <= '0;
          reason    <= step.code;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trigger_level <= step.trig;
      busy_res      <= step.busy;
      done_res      <= step.done;
    end
  end

endmodule
`default_nettype wire

>>> design/ultrasonic_range_measure_core.sv
// A result beat is registered in the phase sequencer and then in the distance
// stage; the path holds two register stages. Throughput: one input beat per
// cycle while out_ready is high; the phase sequencer and the distance stage
// each hold one beat, and the scaling multiplier sits in the second stage.
// Reset is synchronous and active high: the sequencer returns to idle, the last
// result reads as not ready; all but the step, trigger, busy and done registers reset.
`default_nettype none
module ultrasonic_range_measure_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [urm_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [urm_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [urm_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           start_request,
  input  wire logic                           echo_level,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                trigger_level,
  output logic                                busy_res,
  output logic                                done_res,
  output logic                                valid_res,
  output logic                                blocked,
  output logic      [urm_pkg::DIST_BITS-1:0]  distance,
  output logic      [2:0]                     reason
);
  import urm_pkg::*;

  cfg_t  cfg;
  step_t step;
  logic  step_valid;
  logic  step_ready;

  urm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  urm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_request (start_request),
    .echo_level    (echo_level),
    .step_valid    (step_valid),
    .step_ready    (step_ready),
    .step          (step)
  );

  urm_dist u_dist (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step_valid    (step_valid),
    .step_ready    (step_ready),
    .step          (step),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_level (trigger_level),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .valid_res     (valid_res),
    .blocked       (blocked),
    .distance      (distance),
    .reason        (reason)
  );

endmodule
`default_nettype wire
